[sv/hhs_pkg.sv]
// Shared types, codes and constants for the heartbeat health supervisor.
package hhs_pkg;

  // Supervised components and derived widths
  localparam int NUM_COMP   = 8;
  localparam int IDX_W      = $clog2(NUM_COMP);
  localparam int TIME_W     = 32;
  localparam int DEADLINE_W = 24;
  localparam int SLOT_W     = DEADLINE_W + 1;

  // Configuration port
  localparam int PDATA_W = 32;
  localparam int PADDR_W = IDX_W + 2;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Overall health level codes
  localparam logic [1:0] LVL_OK       = 2'd0;
  localparam logic [1:0] LVL_DEGRADED = 2'd1;
  localparam logic [1:0] LVL_FAULT    = 2'd2;

  // Request kind codes on the input channel
  localparam logic [1:0] KIND_MARK_OK       = 2'd0;
  localparam logic [1:0] KIND_MARK_DEGRADED = 2'd1;
  localparam logic [1:0] KIND_MARK_FAULT    = 2'd2;
  localparam logic [1:0] KIND_EVALUATE      = 2'd3;

  // Per-component watch slot: required bit over deadline in ms
  typedef struct packed {
    logic                  required;
    logic [DEADLINE_W-1:0] deadline;
  } slot_t;

  typedef slot_t [NUM_COMP-1:0] slot_arr_t;

  // Input request payload
  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        component;
    logic [TIME_W-1:0] now_ms;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic [1:0] level;
    logic       quorum_ok;
    logic [2:0] first_failing;
    logic       failing_was_stale;
    logic [7:0] failed_mask;
    logic [7:0] degraded_mask;
  } out_rsp_t;

  // Decoded command operation
  typedef enum logic [1:0] {
    OP_MARK_OK,
    OP_MARK_DEGRADED,
    OP_MARK_FAULT,
    OP_EVALUATE
  } cmd_op_t;

  // Command carried through the queue
  typedef struct packed {
    cmd_op_t           op;
    logic [IDX_W-1:0]  comp;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

  // Reset value of each watch slot
  function automatic slot_t slot_reset(input int idx);
    slot_t s;
    case (idx)
      0:       s = '{required: 1'b1, deadline: DEADLINE_W'(2000)};
      1:       s = '{required: 1'b1, deadline: DEADLINE_W'(180000)};
      2, 3, 4: s = '{required: 1'b1, deadline: DEADLINE_W'(30000)};
      5, 6:    s = '{required: 1'b0, deadline: DEADLINE_W'(120000)};
      7:       s = '{required: 1'b0, deadline: DEADLINE_W'(60000)};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

[sv/hhs_regs.sv]
// Watch slot register file behind the APB-style configuration port.
module hhs_regs import hhs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output slot_arr_t          slots
);

  slot_arr_t        slot_r;
  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register write, one slot per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        slot_r[i] <= slot_reset(i);
      end
    end else if (wr_en) begin
      slot_r[reg_idx] <= pwdata[SLOT_W-1:0];
    end
  end

  // Read back, zero above the slot bits
  assign prdata = PDATA_W'(slot_r[reg_idx]);
  assign slots  = slot_r;

endmodule

[sv/hhs_front.sv]
// Front end: takes requests, decodes them into commands for the queue.
module hhs_front import hhs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  in_req_t in_data,
  output logic    cmd_valid,
  input  logic    cmd_ready,
  output cmd_t    cmd
);

  cmd_t    cmd_r;
  logic    cmd_vld_r;
  cmd_op_t op;
  logic    drop;
  logic    take;

  // Decode kind; marks on a component that does not exist are dropped
  always_comb begin
    case (in_data.kind)
      KIND_MARK_OK:       op = OP_MARK_OK;
      KIND_MARK_DEGRADED: op = OP_MARK_DEGRADED;
      KIND_MARK_FAULT:    op = OP_MARK_FAULT;
      default:            op = OP_EVALUATE;
    endcase
    drop = (op != OP_EVALUATE) && ({1'b0, in_data.component} >= 4'(NUM_COMP));
  end

  assign in_ready = !cmd_vld_r || cmd_ready;
  assign take     = in_valid && in_ready;

  // Staging register in front of the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else if (in_ready) begin
      cmd_vld_r <= take && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r.op     <= op;
      cmd_r.comp   <= in_data.component[IDX_W-1:0];
      cmd_r.now_ms <= in_data.now_ms;
    end
  end

  assign cmd_valid = cmd_vld_r;
  assign cmd       = cmd_r;

endmodule

[sv/hhs_queue.sv]
// Short command queue that decouples the front end from the back end.
module hhs_queue import hhs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entry_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      if (pop)  rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      case ({push, pop})
        2'b10:   count_r <= (QPTR_W+1)'(count_r + 1'b1);
        2'b01:   count_r <= (QPTR_W+1)'(count_r - 1'b1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

[sv/hhs_back.sv]
// Back end: applies marks and scans the components for an evaluate.
module hhs_back import hhs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  slot_arr_t slots,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_rsp_t  out_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_COMP - 1);

  bk_state_t         state_r, state_nxt;

  // Component state
  logic [TIME_W-1:0] last_r [NUM_COMP];
  logic [NUM_COMP-1:0] fault_r;
  logic [NUM_COMP-1:0] degr_r;

  // Scan accumulators
  logic [IDX_W-1:0]    idx_r;
  logic [TIME_W-1:0]   now_r;
  logic [NUM_COMP-1:0] fmask_r;
  logic [NUM_COMP-1:0] dmask_r;
  logic                quorum_r;
  logic [IDX_W-1:0]    first_r;
  logic                stale_r;

  // Output register
  out_rsp_t out_r;
  logic     out_vld_r;

  logic              pop;
  logic              pop_eval;
  logic              out_free;
  logic              load_out;
  slot_t             cur_slot;
  logic [TIME_W-1:0] elapsed;
  logic              cur_stale;
  logic              cur_failed;

  assign cmd_ready = (state_r == BK_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign pop_eval  = pop && (cmd.op == OP_EVALUATE);
  assign out_free  = !out_vld_r || out_ready;
  assign load_out  = (state_r == BK_DONE) && out_free;

  // Shared subtract-compare unit, one component per cycle
  always_comb begin
    cur_slot   = slots[idx_r];
    elapsed    = now_r - last_r[idx_r];
    cur_stale  = (cur_slot.deadline != '0) &&
                 (elapsed > TIME_W'(cur_slot.deadline));
    cur_failed = fault_r[idx_r] || cur_stale;
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop_eval) state_nxt = BK_SCAN;
      end
      BK_SCAN: begin
        if (idx_r == LAST_IDX) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Mark updates to the component state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        last_r[i] <= '0;
      end
      fault_r <= '0;
      degr_r  <= '0;
    end else if (pop && !pop_eval) begin
      last_r[cmd.comp]  <= cmd.now_ms;
      fault_r[cmd.comp] <= (cmd.op == OP_MARK_FAULT);
      degr_r[cmd.comp]  <= (cmd.op == OP_MARK_DEGRADED);
    end
  end

  // Scan accumulators
  always_ff @(posedge clk) begin
    if (pop_eval) begin
      now_r    <= cmd.now_ms;
      idx_r    <= '0;
      fmask_r  <= '0;
      dmask_r  <= '0;
      quorum_r <= 1'b1;
      first_r  <= '0;
      stale_r  <= 1'b0;
    end else if (state_r == BK_SCAN) begin
      fmask_r[idx_r] <= cur_failed;
      dmask_r[idx_r] <= degr_r[idx_r];
      if (cur_failed && cur_slot.required && quorum_r) begin
        quorum_r <= 1'b0;
        first_r  <= idx_r;
        stale_r  <= cur_stale;
      end
      idx_r <= IDX_W'(idx_r + 1'b1);
    end
  end

  // Result register, held until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (fmask_r != '0) begin
        out_r.level <= LVL_FAULT;
      end else if (dmask_r != '0) begin
        out_r.level <= LVL_DEGRADED;
      end else begin
        out_r.level <= LVL_OK;
      end
      out_r.quorum_ok         <= quorum_r;
      out_r.first_failing     <= first_r;
      out_r.failing_was_stale <= stale_r;
      out_r.failed_mask       <= fmask_r;
      out_r.degraded_mask     <= dmask_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[sv/heartbeat_health_supervisor.sv]
// Heartbeat health supervisor top level: front end, command queue, back end, registers.
// Mark requests: staged in the front end, queued, then applied by the back end; one mark per
// cycle sustained while the back end is idle. Evaluate requests: the back end takes no new
// command while it holds an evaluate (dispatch, 8 scan steps through one shared
// subtract-compare unit, result load). A 4-entry queue buffers requests meanwhile.
// Reset (synchronous, rst_n low): watch slots to defaults, heartbeat state cleared, queue empty.
module heartbeat_health_supervisor import hhs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_req_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_rsp_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  slot_arr_t slots;
  logic      fq_valid;
  logic      fq_ready;
  cmd_t      fq_cmd;
  logic      qb_valid;
  logic      qb_ready;
  cmd_t      qb_cmd;

  // Configuration registers
  hhs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .slots   (slots)
  );

  // Request decode
  hhs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  // Command queue
  hhs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // Mark and evaluate execution
  hhs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .slots     (slots),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/heartbeat_health_supervisor_test.sv]
// Self-checking testbench for the heartbeat health supervisor: marks, evaluates, slot setup.
`timescale 1ns / 1ps

module heartbeat_health_supervisor_test;
  import hhs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int STALL_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 125;
  localparam int PHASES         = 6;

  // One row of the directed table; typed rows carry their result by hand
  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_req_t            in_data;
  logic               out_valid;
  logic               out_ready;
  out_rsp_t           out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Health model state
  slot_arr_t         watch_cfg;
  logic [TIME_W-1:0] beat_time [NUM_COMP];
  bit                fault_f   [NUM_COMP];
  bit                degr_f    [NUM_COMP];
  out_rsp_t          pending_health [$];

  int mismatches;
  int quiet_cycles;
  bit calm;
  bit stall_out_req;
  dir_row_t dir_rows [$];

  heartbeat_health_supervisor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when no request or result moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("heartbeat_health_supervisor verification failed");
      $finish;
    end
  end

  task automatic model_reset();
    watch_cfg[0] = '{required: 1'b1, deadline: DEADLINE_W'(2000)};
    watch_cfg[1] = '{required: 1'b1, deadline: DEADLINE_W'(180000)};
    watch_cfg[2] = '{required: 1'b1, deadline: DEADLINE_W'(30000)};
    watch_cfg[3] = '{required: 1'b1, deadline: DEADLINE_W'(30000)};
    watch_cfg[4] = '{required: 1'b1, deadline: DEADLINE_W'(30000)};
    watch_cfg[5] = '{required: 1'b0, deadline: DEADLINE_W'(120000)};
    watch_cfg[6] = '{required: 1'b0, deadline: DEADLINE_W'(120000)};
    watch_cfg[7] = '{required: 1'b0, deadline: DEADLINE_W'(60000)};
    for (int i = 0; i < NUM_COMP; i++) begin
      beat_time[i] = '0;
      fault_f[i]   = 1'b0;
      degr_f[i]    = 1'b0;
    end
  endtask

  // Health summary at time now from the model's flags and heartbeat times
  function automatic out_rsp_t health_eval(logic [TIME_W-1:0] now);
    out_rsp_t          r;
    logic [TIME_W-1:0] age;
    logic              stale;
    logic              failed;
    r = '0;
    r.quorum_ok = 1'b1;
    for (int i = 0; i < NUM_COMP; i++) begin
      age    = now - beat_time[i];
      stale  = (watch_cfg[i].deadline != '0) &&
               (age > {{(TIME_W-DEADLINE_W){1'b0}}, watch_cfg[i].deadline});
      failed = fault_f[i] || stale;
      if (failed) begin
        r.failed_mask[i] = 1'b1;
        r.level = LVL_FAULT;
      end else if (degr_f[i] && r.level == LVL_OK) begin
        r.level = LVL_DEGRADED;
      end
      if (degr_f[i]) r.degraded_mask[i] = 1'b1;
      // quorum drops at the lowest failed required component
      if (failed && watch_cfg[i].required && r.quorum_ok) begin
        r.quorum_ok = 1'b0;
        r.first_failing = 3'(i);
        r.failing_was_stale = stale;
      end
    end
    return r;
  endfunction

  // Apply one accepted request to the model
  task automatic note_request(input in_req_t req);
    if (req.kind == KIND_EVALUATE) begin
      pending_health.push_back(health_eval(req.now_ms));
    end else begin
      beat_time[req.component] = req.now_ms;
      fault_f[req.component]   = (req.kind == KIND_MARK_FAULT);
      degr_f[req.component]    = (req.kind == KIND_MARK_DEGRADED);
    end
  endtask

  // Offer one request; returns at the edge where it is accepted
  task automatic offer_request(input in_req_t req);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic check_result(input out_rsp_t got);
    out_rsp_t want;
    if (pending_health.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: level=%0d quorum=%0b first=%0d stale=%0b fail=%h deg=%h",
                 got.level, got.quorum_ok, got.first_failing, got.failing_was_stale,
                 got.failed_mask, got.degraded_mask);
    end else begin
      want = pending_health.pop_front();
      if (got.level !== want.level || got.quorum_ok !== want.quorum_ok ||
          got.first_failing !== want.first_failing ||
          got.failing_was_stale !== want.failing_was_stale ||
          got.failed_mask !== want.failed_mask || got.degraded_mask !== want.degraded_mask) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  exp: level=%0d quorum=%0b first=%0d stale=%0b fail=%h deg=%h",
                   want.level, want.quorum_ok, want.first_failing, want.failing_was_stale,
                   want.failed_mask, want.degraded_mask);
          $display("  got: level=%0d quorum=%0b first=%0d stale=%0b fail=%h deg=%h",
                   got.level, got.quorum_ok, got.first_failing, got.failing_was_stale,
                   got.failed_mask, got.degraded_mask);
        end
      end
    end
  endtask

  // Result side: random ready gaps, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_out_req) begin
        stall_out_req = 1'b0;
        gap = STALL_CYCLES;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 5);
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
    end
  end

  task automatic write_slot(input int idx, input slot_t s);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    // upper bits are junk that the register must drop
    pwdata  <= {7'($urandom), s};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    watch_cfg[idx] = s;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_slot_check(input int idx);
    logic [PDATA_W-1:0] want;
    want = {{(PDATA_W-SLOT_W){1'b0}}, watch_cfg[idx]};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("slot %0d readback: exp %h got %h", idx, want, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every result is in and queued marks have landed
  task automatic drain_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_health.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Slot settings per phase: max, zero, tiny deadlines, random, mixed
  task automatic program_slots(input int phase);
    slot_t s;
    for (int i = 0; i < NUM_COMP; i++) begin
      case (phase)
        1: s = '1;
        2: s = '0;
        3: s = '{required: 1'($urandom), deadline: DEADLINE_W'($urandom_range(1, 64))};
        4: s = SLOT_W'($urandom);
        default: begin
          s.required = 1'($urandom);
          case ($urandom_range(0, 3))
            0: s.deadline = DEADLINE_W'(1);
            1: s.deadline = '1;
            2: s.deadline = DEADLINE_W'($urandom_range(1, 5000));
            default: s.deadline = '0;
          endcase
        end
      endcase
      write_slot(i, s);
    end
    for (int i = 0; i < NUM_COMP; i++) read_slot_check(i);
  endtask

  function automatic dir_row_t dir_row(logic [1:0] kind, logic [2:0] comp,
                                       logic [TIME_W-1:0] now, bit typed, out_rsp_t rsp);
    dir_row_t row;
    row.req   = '{kind: kind, component: comp, now_ms: now};
    row.typed = typed;
    row.rsp   = rsp;
    return row;
  endfunction

  // Mostly well-formed heartbeat traffic on a running clock, some noise
  task automatic run_random(input int phase, input int count);
    in_req_t           req;
    logic [TIME_W-1:0] clock_ms;
    int                c;
    int                pick;
    clock_ms = $urandom_range(0, 1) ? TIME_W'($urandom)
                                    : 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 5000));
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      if (phase == 3 && k == 40) stall_out_req = 1'b1;
      pick = $urandom_range(0, 99);
      c    = $urandom_range(0, NUM_COMP - 1);
      req.component = 3'($urandom);
      if (pick < 15) begin
        // noise: anything at any time
        req.kind   = 2'($urandom);
        req.now_ms = TIME_W'($urandom);
      end else if (pick < 50) begin
        case ($urandom_range(0, 5))
          0:       req.kind = KIND_MARK_FAULT;
          1, 2:    req.kind = KIND_MARK_DEGRADED;
          default: req.kind = KIND_MARK_OK;
        endcase
        clock_ms   = clock_ms + TIME_W'($urandom_range(0, 50));
        req.now_ms = clock_ms;
      end else if (pick < 75) begin
        // evaluate right at one component's deadline edge
        req.kind   = KIND_EVALUATE;
        req.now_ms = beat_time[c] + TIME_W'(watch_cfg[c].deadline)
                     + TIME_W'($urandom_range(0, 3)) - 32'd1;
      end else begin
        req.kind = KIND_EVALUATE;
        case ($urandom_range(0, 3))
          0: clock_ms = clock_ms + TIME_W'($urandom_range(0, 10));
          1: clock_ms = clock_ms + TIME_W'($urandom_range(0, 1000));
          2: clock_ms = clock_ms + TIME_W'($urandom_range(0, 100000));
          default: clock_ms = clock_ms + TIME_W'($urandom);
        endcase
        req.now_ms = clock_ms;
      end
      offer_request(req);
      note_request(req);
    end
  endtask

  // Main sequence
  initial begin : stimulus
    out_rsp_t all_ok;
    out_rsp_t c0_stale;
    out_rsp_t all_stale;
    out_rsp_t no_rsp;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    stall_out_req = 1'b0;
    model_reset();

    all_ok    = '{level: LVL_OK, quorum_ok: 1'b1, first_failing: 3'd0,
                  failing_was_stale: 1'b0, failed_mask: 8'h00, degraded_mask: 8'h00};
    c0_stale  = '{level: LVL_FAULT, quorum_ok: 1'b0, first_failing: 3'd0,
                  failing_was_stale: 1'b1, failed_mask: 8'h01, degraded_mask: 8'h00};
    all_stale = '{level: LVL_FAULT, quorum_ok: 1'b0, first_failing: 3'd0,
                  failing_was_stale: 1'b1, failed_mask: 8'hFF, degraded_mask: 8'h00};
    no_rsp    = '0;

    // Directed rows: reset state, deadline edges, wrap, every kind, quorum cases
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd7, 32'd0, 1'b1, all_ok));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd0, 32'd2001, 1'b1, c0_stale));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd3, 32'd2000, 1'b1, all_ok));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd5, 32'hFFFF_FFFF, 1'b1, all_stale));
    dir_rows.push_back(dir_row(KIND_MARK_OK, 3'd0, 32'hFFFF_FFFF, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd1, 32'd1999, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd2, 32'd2000, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_DEGRADED, 3'd7, 32'd2000, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_OK, 3'd0, 32'd2000, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd5, 32'd2000, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_FAULT, 3'd6, 32'd2000, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd6, 32'd2000, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_FAULT, 3'd3, 32'd2000, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd4, 32'd2000, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_OK, 3'd0, 32'd32001, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_OK, 3'd1, 32'd32001, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_OK, 3'd2, 32'd32001, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd0, 32'd32001, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_DEGRADED, 3'd3, 32'd32001, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_MARK_OK, 3'd4, 32'd32001, 1'b0, no_rsp));
    dir_rows.push_back(dir_row(KIND_EVALUATE, 3'd7, 32'd32001, 1'b0, no_rsp));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_COMP; i++) read_slot_check(i);

    foreach (dir_rows[r]) begin
      offer_request(dir_rows[r].req);
      if (dir_rows[r].typed) pending_health.push_back(dir_rows[r].rsp);
      else note_request(dir_rows[r].req);
    end
    run_random(0, RANDOM_ITEMS);

    for (int ph = 1; ph < PHASES; ph++) begin
      drain_idle();
      program_slots(ph);
      run_random(ph, RANDOM_ITEMS);
    end
    drain_idle();

    if (mismatches == 0) begin
      $display("heartbeat_health_supervisor verification clean");
    end else begin
      $display("heartbeat_health_supervisor verification failed");
    end
    $finish;
  end

endmodule
